// ----- hw/rtl/ctmc_pkg.sv -----
// Shared types and constants for the coolant thermal mode controller.
// No dependencies; every other file imports this package.
package ctmc_pkg;

  localparam int unsigned TEMP_W   = 12;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned DUR_W    = 20;
  localparam int unsigned DUTY_W   = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  typedef enum logic [2:0] {
    MODE_OFF    = 3'd0,
    MODE_PRIME  = 3'd1,
    MODE_IDLE   = 3'd2,
    MODE_ACTIVE = 3'd3,
    MODE_BOOST  = 3'd4,
    MODE_DERATE = 3'd5,
    MODE_FAULT  = 3'd6,
    MODE_MAINT  = 3'd7
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_TEMP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DERATE_TEMP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_TEMP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RETURN_TEMP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST_DURATION  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_FAN_DUTY = 3'd5;

  localparam logic signed [TEMP_W-1:0] CRITICAL_TEMP_RST = 12'sd950;
  localparam logic signed [TEMP_W-1:0] DERATE_TEMP_RST   = 12'sd750;
  localparam logic signed [TEMP_W-1:0] ACTIVE_TEMP_RST   = 12'sd670;
  localparam logic signed [TEMP_W-1:0] RETURN_TEMP_RST   = 12'sd650;
  localparam logic [DUR_W-1:0]         BOOST_DUR_RST     = 20'd30000;
  localparam logic [DUTY_W-1:0]        FAN_DUTY_RST      = 7'd50;
  localparam logic [DUTY_W-1:0]        FAN_FULL          = 7'd100;

  typedef struct packed {
    logic [TIME_W-1:0]        time_ms;
    logic signed [TEMP_W-1:0] temperature;
    logic                     level_good;
    logic                     ignition_on;
    logic                     pump_good;
    logic                     derate_request;
    logic                     reset_request;
  } sample_t;

  typedef struct packed {
    mode_t             mode;
    logic              pump_on;
    logic [DUTY_W-1:0] fan_duty;
    logic              inverter_limit;
    logic              alarm_on;
  } result_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] critical_temp;
    logic signed [TEMP_W-1:0] derate_temp;
    logic signed [TEMP_W-1:0] active_temp;
    logic signed [TEMP_W-1:0] return_temp;
    logic [DUR_W-1:0]         boost_duration;
    logic [DUTY_W-1:0]        active_fan_duty;
  } cfg_t;

  // State update and result produced by the mode logic for one sample.
  typedef struct packed {
    mode_t             mode;
    logic [TIME_W-1:0] boost_deadline;
    result_t           res;
  } step_t;

endpackage

// ----- hw/rtl/ctmc_sample_if.sv -----
// Sample channel: valid/ready handshake plus the input fields.
// Depends on ctmc_pkg.
interface ctmc_sample_if;
  import ctmc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [TIME_W-1:0]        time_ms;
  logic signed [TEMP_W-1:0] temperature;
  logic                     level_good;
  logic                     ignition_on;
  logic                     pump_good;
  logic                     derate_request;
  logic                     reset_request;

  modport source (
    output valid, time_ms, temperature, level_good, ignition_on, pump_good,
           derate_request, reset_request,
    input  ready
  );
  modport sink (
    input  valid, time_ms, temperature, level_good, ignition_on, pump_good,
           derate_request, reset_request,
    output ready
  );
endinterface

// ----- hw/rtl/ctmc_result_if.sv -----
// Result channel: valid/ready handshake plus the output fields.
// Depends on ctmc_pkg.
interface ctmc_result_if;
  import ctmc_pkg::*;

  logic              valid;
  logic              ready;
  logic [2:0]        mode;
  logic              pump_on;
  logic [DUTY_W-1:0] fan_duty;
  logic              inverter_limit;
  logic              alarm_on;

  modport source (
    output valid, mode, pump_on, fan_duty, inverter_limit, alarm_on,
    input  ready
  );
  modport sink (
    input  valid, mode, pump_on, fan_duty, inverter_limit, alarm_on,
    output ready
  );
endinterface

// ----- hw/rtl/ctmc_cfg_if.sv -----
// Configuration write channel: valid/ready, register index and write data.
// Depends on ctmc_pkg.
interface ctmc_cfg_if;
  import ctmc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/ctmc_mode_logic.sv -----
// Combinational mode logic for one sample: overrides, per-mode rules, outputs.
// Depends on ctmc_pkg.
module ctmc_mode_logic (
  input  ctmc_pkg::mode_t   mode,
  input  logic [31:0]       boost_deadline,
  input  ctmc_pkg::sample_t smp,
  input  ctmc_pkg::cfg_t    cfg,
  output ctmc_pkg::step_t   step
);
  import ctmc_pkg::*;

  mode_t             mode_ovr;
  mode_t             mode_case;
  mode_t             mode_next;
  logic              boost_entry;
  logic [TIME_W-1:0] deadline;
  logic [TIME_W-1:0] elapsed;
  logic              boost_done;
  logic              ge_act;
  logic              ge_der;
  logic              le_ret;
  logic [DUTY_W-1:0] act_fan;
  result_t           res;

  always_comb begin
    mode_ovr = mode;
    if (!smp.level_good && mode != MODE_FAULT) begin
      mode_ovr = MODE_FAULT;
    end
    boost_entry = (smp.temperature >= cfg.critical_temp) && (mode_ovr != MODE_BOOST);
    mode_case   = boost_entry ? MODE_BOOST : mode_ovr;
    deadline    = boost_entry ? smp.time_ms + {{(TIME_W-DUR_W){1'b0}}, cfg.boost_duration}
                              : boost_deadline;
    elapsed     = smp.time_ms - deadline;
    boost_done  = !elapsed[TIME_W-1];
  end

  assign ge_act  = smp.temperature >= cfg.active_temp;
  assign ge_der  = smp.temperature >= cfg.derate_temp;
  assign le_ret  = smp.temperature <= cfg.return_temp;
  assign act_fan = (cfg.active_fan_duty > FAN_FULL) ? FAN_FULL : cfg.active_fan_duty;

  // Rules inside a mode run in order; the last one that matches wins.
  always_comb begin
    mode_next          = mode_case;
    res.pump_on        = 1'b0;
    res.fan_duty       = '0;
    res.inverter_limit = 1'b0;
    res.alarm_on       = 1'b0;
    unique case (mode_case)
      MODE_OFF: begin
        res.inverter_limit = 1'b1;
        if (smp.ignition_on) mode_next = MODE_PRIME;
      end
      MODE_PRIME: begin
        res.pump_on        = 1'b1;
        res.inverter_limit = 1'b1;
        if (!smp.level_good) mode_next = MODE_FAULT;
        if (smp.pump_good) mode_next = MODE_IDLE;
      end
      MODE_IDLE: begin
        res.pump_on = 1'b1;
        if (!smp.ignition_on) mode_next = MODE_OFF;
        if (smp.derate_request) mode_next = MODE_DERATE;
        if (ge_act) mode_next = MODE_ACTIVE;
      end
      MODE_ACTIVE: begin
        res.pump_on  = 1'b1;
        res.fan_duty = act_fan;
        if (!smp.ignition_on) mode_next = MODE_OFF;
        if (!smp.level_good) mode_next = MODE_FAULT;
        if (ge_der) mode_next = MODE_DERATE;
        if (le_ret) mode_next = MODE_IDLE;
      end
      MODE_BOOST: begin
        res.pump_on        = 1'b1;
        res.fan_duty       = FAN_FULL;
        res.inverter_limit = 1'b1;
        if (!smp.level_good) mode_next = MODE_FAULT;
        if (boost_done) begin
          if (ge_der) mode_next = MODE_DERATE;
          else if (le_ret) mode_next = MODE_IDLE;
          else mode_next = MODE_ACTIVE;
        end
      end
      MODE_DERATE: begin
        res.pump_on        = 1'b1;
        res.fan_duty       = FAN_FULL;
        res.inverter_limit = 1'b1;
        if (!smp.level_good) mode_next = MODE_FAULT;
        if (le_ret && !smp.derate_request) mode_next = MODE_IDLE;
      end
      MODE_FAULT: begin
        res.fan_duty       = FAN_FULL;
        res.inverter_limit = 1'b1;
        res.alarm_on       = 1'b1;
        if (smp.reset_request && smp.level_good && smp.pump_good) mode_next = MODE_PRIME;
      end
      MODE_MAINT: begin
      end
      default: begin
      end
    endcase
    res.mode = mode_next;
  end

  assign step.mode           = mode_next;
  assign step.boost_deadline = deadline;
  assign step.res            = res;

endmodule

// ----- hw/rtl/coolant_thermal_mode_controller_top.sv -----
// Coolant thermal mode controller, top level.
// A transferred sample is held in the sample register; its result enters the result register
// once the result side is free. Throughput: one sample per cycle while the result side is ready;
// the mode logic is one combinational pass between the sample register and the result register.
// Reset (rst, synchronous): mode off, boost deadline 0, config registers at defaults, no items held.
// Depends on ctmc_pkg, the channel interfaces and ctmc_mode_logic.
module coolant_thermal_mode_controller_top (
  input  logic       clk,
  input  logic       rst,
  ctmc_sample_if.sink   sample,
  ctmc_result_if.source result,
  ctmc_cfg_if.sink      cfg
);
  import ctmc_pkg::*;

  logic              s1_valid;
  sample_t           s1;
  logic              o_valid;
  result_t           o_res;
  mode_t             mode_q;
  logic [TIME_W-1:0] deadline_q;
  cfg_t              cfg_q;
  step_t             step;
  logic              fire;
  logic              take;

  assign fire         = s1_valid && (!o_valid || result.ready);
  assign take         = sample.valid && sample.ready;
  assign sample.ready = !s1_valid || fire;
  assign cfg.ready    = 1'b1;

  ctmc_mode_logic u_logic (
    .mode           (mode_q),
    .boost_deadline (deadline_q),
    .smp            (s1),
    .cfg            (cfg_q),
    .step           (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      o_valid    <= 1'b0;
      mode_q     <= MODE_OFF;
      deadline_q <= '0;
      cfg_q      <= '{critical_temp: CRITICAL_TEMP_RST, derate_temp: DERATE_TEMP_RST,
                      active_temp: ACTIVE_TEMP_RST, return_temp: RETURN_TEMP_RST,
                      boost_duration: BOOST_DUR_RST, active_fan_duty: FAN_DUTY_RST};
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (fire) begin
        s1_valid <= 1'b0;
      end
      if (fire) begin
        o_valid    <= 1'b1;
        mode_q     <= step.mode;
        deadline_q <= step.boost_deadline;
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_CRITICAL_TEMP:   cfg_q.critical_temp   <= signed'(cfg.data[TEMP_W-1:0]);
          CFG_DERATE_TEMP:     cfg_q.derate_temp     <= signed'(cfg.data[TEMP_W-1:0]);
          CFG_ACTIVE_TEMP:     cfg_q.active_temp     <= signed'(cfg.data[TEMP_W-1:0]);
          CFG_RETURN_TEMP:     cfg_q.return_temp     <= signed'(cfg.data[TEMP_W-1:0]);
          CFG_BOOST_DURATION:  cfg_q.boost_duration  <= cfg.data[DUR_W-1:0];
          CFG_ACTIVE_FAN_DUTY: cfg_q.active_fan_duty <= cfg.data[DUTY_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      s1 <= '{time_ms: sample.time_ms, temperature: sample.temperature,
              level_good: sample.level_good, ignition_on: sample.ignition_on,
              pump_good: sample.pump_good, derate_request: sample.derate_request,
              reset_request: sample.reset_request};
    end
    if (fire) begin
      o_res <= step.res;
    end
  end

  assign result.valid          = o_valid;
  assign result.mode           = o_res.mode;
  assign result.pump_on        = o_res.pump_on;
  assign result.fan_duty       = o_res.fan_duty;
  assign result.inverter_limit = o_res.inverter_limit;
  assign result.alarm_on       = o_res.alarm_on;

  // Mode register tracks the mode of the latest result.
  a_mode_tracks: assert property (@(posedge clk) disable iff (rst)
    fire |=> (mode_q == o_res.mode))
    else $error("mode register differs from last result mode");

  // Alarm is raised only when the fault rules run, and that step can only leave toward prime.
  a_alarm_mode: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_res.alarm_on) |-> (o_res.mode == MODE_FAULT || o_res.mode == MODE_PRIME))
    else $error("alarm with unexpected mode");

  // A held sample is not dropped while the result side stalls.
  a_sample_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !fire) |=> s1_valid)
    else $error("held sample lost");

  a_reset_state: assert property (@(posedge clk)
    $past(rst) |-> (mode_q == MODE_OFF && !o_valid && !s1_valid))
    else $error("state not cleared by reset");

endmodule
